/* hdl/bjc_pkg.sv */
package bjc_pkg;

  // Fixed field widths.
  localparam int JUMP_W  = 11;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 11;

  // Saturation limit of a jump count and clamp of a stored jump.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;
  localparam logic [JUMP_W-1:0]  MAX_JUMP  = 11'd1024;

  // Default table depth.
  localparam int DEF_MAX_POSITIONS = 1024;

  // Register reset values.
  localparam logic [CFG_W-1:0] N_POS_RESET     = 11'd1024;
  localparam logic [CFG_W-1:0] BLOCK_LEN_RESET = 11'd32;

  // Configuration register indexes.
  localparam logic CFG_N_POSITIONS = 1'b0;
  localparam logic CFG_BLOCK_LEN   = 1'b1;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_LOAD    = 2'd2,
    OP_REBUILD = 2'd3
  } opcode_e;

endpackage

/* hdl/bjc_rem.sv */
module bjc_rem
  import bjc_pkg::*;
#(
  parameter int AW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AW-1:0]     dividend_i,
  input  logic [CFG_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CFG_W-1:0]  rem_o
);

  localparam int CW = $clog2(AW + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW-1:0]    dv_q, dv_d;
  logic [CFG_W-1:0] r_q, r_d;
  logic [CFG_W:0]   sh;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dv_d   = dv_q;
    r_d    = r_q;
    sh     = {r_q, dv_q[AW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(AW);
      dv_d   = dividend_i;
      r_d    = '0;
    end else if (busy_q) begin
      dv_d = dv_q << 1;
      if (sh >= {1'b0, divisor_i}) begin
        r_d = CFG_W'(sh - {1'b0, divisor_i});
      end else begin
        r_d = sh[CFG_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
    r_q  <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

/* hdl/blocked_jump_count_table_unit.sv */
// Blocked jump-count table.
// Input channel (in_valid_i/in_ready_o) takes one word: opcode, position, jump.
// A query returns one word on the output channel (out_valid_o/out_ready_i)
// with the number of jumps needed to walk off the table; update, load and
// rebuild-all return nothing. Registers are written on cfg_we_i; the user
// must write them only while idle, as the block does not enforce it. The
// block works on one word at a time; in_ready_o is high only when idle. A
// query does a link read and a step per block visited before its result is
// offered; an update writes the jump, finds the block start by division and
// rebuilds that block position by position (jump read, chaining, link write);
// a load is a single write; a rebuild-all rebuilds each block in use in turn.
// Each step rests on a dependent read of the single link memory read port.
// At reset the registers take n_positions 1024 and block_len 32 and the
// tables hold nothing valid: every position must be loaded and rebuilt
// before a query. A finished query result waits in the output register while
// the receiver stalls; a further word may be accepted, but a second query
// holds its result until the first is taken.
module blocked_jump_count_table_unit
  import bjc_pkg::*;
#(
  parameter int MAX_POSITIONS = DEF_MAX_POSITIONS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [CFG_W-1:0]                     cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           opcode_i,
  input  logic [$clog2(MAX_POSITIONS)-1:0]     position_i,
  input  logic [JUMP_W-1:0]                    jump_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [COUNT_W-1:0]                   jump_count_o
);

  localparam int AW = $clog2(MAX_POSITIONS);
  localparam int LW = AW + 1;
  localparam int WW = ((AW + 1 > 11) ? AW + 1 : 11) + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_Q_RD  = 4'd1;
  localparam logic [3:0] S_Q_EX  = 4'd2;
  localparam logic [3:0] S_Q_OUT = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RB    = 4'd5;
  localparam logic [3:0] S_J_RD  = 4'd6;
  localparam logic [3:0] S_J_EX  = 4'd7;
  localparam logic [3:0] S_L_EX  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [CFG_W-1:0]   n_q, len_q;
  logic [WW-1:0]      neff, leneff;
  logic [AW-1:0]      x_q, x_d, j_q, j_d, pos_q, pos_d;
  logic [WW-1:0]      start_q, start_d, end_q, end_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               all_q, all_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_q, out_d;

  // Memories: jump distances, and the link pair {steps, landing}.
  logic [JUMP_W-1:0]          jmem [MAX_POSITIONS];
  logic [COUNT_W+LW-1:0]      lmem [MAX_POSITIONS];
  logic [JUMP_W-1:0]          jrd_q;
  logic [COUNT_W+LW-1:0]      lrd_q;
  logic                       jwe, lwe;
  logic [AW-1:0]              jwaddr, lraddr;
  logic [JUMP_W-1:0]          jwdata;
  logic [COUNT_W+LW-1:0]      lwdata;

  logic [JUMP_W-1:0]  jclamp;
  logic [COUNT_W-1:0] rd_steps;
  logic [LW-1:0]      rd_land;
  logic [COUNT_W:0]   cnt_sum, step_sum;
  logic [WW-1:0]      t_w, end_w;
  logic               div_start, div_done;
  logic [CFG_W-1:0]   rem;
  logic               in_acc;

  // Effective register values.
  always_comb begin
    neff = WW'(n_q);
    if (n_q == '0) neff = WW'(1);
    else if (WW'(n_q) > WW'(MAX_POSITIONS)) neff = WW'(MAX_POSITIONS);
    leneff = (len_q == '0) ? WW'(1) : WW'(len_q);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= N_POS_RESET;
      len_q <= BLOCK_LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_N_POSITIONS) n_q <= cfg_wdata_i;
      if (cfg_index_i == CFG_BLOCK_LEN) len_q <= cfg_wdata_i;
    end
  end

  // Block start: position minus its remainder by the block length.
  bjc_rem #(.AW(AW)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pos_d),
    .divisor_i  (leneff[CFG_W-1:0]),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign rd_steps   = lrd_q[COUNT_W+LW-1:LW];
  assign rd_land    = lrd_q[LW-1:0];
  assign cnt_sum    = {1'b0, cnt_q} + {1'b0, rd_steps};
  assign step_sum   = {1'b0, rd_steps} + 1'b1;
  assign t_w        = WW'(j_q) + WW'(jrd_q);
  assign end_w      = start_q + leneff;

  // Incoming jump clamped to 1..1024.
  always_comb begin
    jclamp = jump_i;
    if (jump_i == '0) jclamp = JUMP_W'(1);
    else if (jump_i > MAX_JUMP) jclamp = MAX_JUMP;
  end

  // Control sequencer.
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    j_d         = j_q;
    pos_d       = pos_q;
    start_d     = start_q;
    end_d       = end_q;
    cnt_d       = cnt_q;
    all_d       = all_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    jwe         = 1'b0;
    jwaddr      = position_i;
    jwdata      = jclamp;
    lwe         = 1'b0;
    lwdata      = '0;
    lraddr      = x_q;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (opcode_i)
            OP_QUERY: begin
              cnt_d = '0;
              x_d   = position_i;
              if (WW'(position_i) >= neff) state_d = S_Q_OUT;
              else state_d = S_Q_RD;
            end
            OP_UPDATE, OP_LOAD: begin
              if (WW'(position_i) < WW'(MAX_POSITIONS)) begin
                jwe = 1'b1;
                if (opcode_i == OP_UPDATE) begin
                  pos_d     = position_i;
                  all_d     = 1'b0;
                  div_start = 1'b1;
                  state_d   = S_DIV;
                end
              end
            end
            default: begin
              start_d = '0;
              all_d   = 1'b1;
              state_d = S_RB;
            end
          endcase
        end
      end
      S_Q_RD: begin
        state_d = S_Q_EX;
      end
      S_Q_EX: begin
        cnt_d = cnt_sum[COUNT_W] ? COUNT_MAX : cnt_sum[COUNT_W-1:0];
        if (WW'(rd_land) <= WW'(x_q) || WW'(rd_land) >= neff) begin
          state_d = S_Q_OUT;
        end else begin
          x_d     = rd_land[AW-1:0];
          state_d = S_Q_RD;
        end
      end
      S_Q_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = cnt_q;
          state_d     = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          start_d = WW'(pos_q) - WW'(rem);
          state_d = S_RB;
        end
      end
      S_RB: begin
        if (start_q >= neff) begin
          state_d = S_IDLE;
        end else begin
          end_d   = (end_w > neff) ? neff : end_w;
          j_d     = AW'(((end_w > neff) ? neff : end_w) - 1'b1);
          state_d = S_J_RD;
        end
      end
      S_J_RD: begin
        state_d = S_J_EX;
      end
      S_J_EX: begin
        lraddr = t_w[AW-1:0];
        if (t_w >= end_q) begin
          lwe    = 1'b1;
          lwdata = {COUNT_W'(1),
                    (t_w > WW'(MAX_POSITIONS)) ? LW'(MAX_POSITIONS) : LW'(t_w)};
          state_d = S_L_EX;
        end else begin
          state_d = S_L_EX;
        end
      end
      S_L_EX: begin
        if (WW'(j_q) + WW'(jrd_q) < end_q) begin
          lwe    = 1'b1;
          lwdata = {step_sum[COUNT_W] ? COUNT_MAX : step_sum[COUNT_W-1:0], rd_land};
        end
        if (WW'(j_q) == start_q) begin
          if (all_q) begin
            start_d = end_w;
            state_d = S_RB;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          j_d     = j_q - 1'b1;
          state_d = S_J_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      all_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      all_q       <= all_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    j_q     <= j_d;
    pos_q   <= pos_d;
    start_q <= start_d;
    end_q   <= end_d;
    cnt_q   <= cnt_d;
    out_q   <= out_d;
  end

  // Jump memory: written on load or update, read at the rebuild cursor.
  always_ff @(posedge clk_i) begin
    if (jwe) jmem[jwaddr] <= jwdata;
    jrd_q <= jmem[j_q];
  end

  // Link memory: written at the rebuild cursor, read for walks and chaining.
  always_ff @(posedge clk_i) begin
    if (lwe) lmem[j_q] <= lwdata;
    lrd_q <= lmem[lraddr];
  end

  assign out_valid_o  = out_valid_q;
  assign jump_count_o = out_q;

  // The rebuild cursor stays inside the block being rebuilt.
  a_cursor_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_J_EX || state_q == S_L_EX) |->
      (WW'(j_q) >= start_q && WW'(j_q) < end_q))
    else $error("rebuild cursor left its block");

  // A walk only visits positions in use.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_EX) |-> (WW'(x_q) < neff))
    else $error("walk position past table end");

  // The block start remainder is below the block length.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |-> (WW'(rem) < leneff))
    else $error("block start remainder out of range");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_Q_OUT && out_valid_q && !out_ready_i) |=> out_valid_o)
    else $error("pending result dropped");

endmodule
